>>> sv/pdd_pkg.sv
// Shared constants, types and state codes for the particle density deposit unit.
package pdd_pkg;

  localparam int GridSize   = 64;
  localparam int FracBits   = 16;
  localparam int WeightBits = 16;
  localparam int PosW       = 22;
  localparam int IdxW       = 18;
  localparam int ValW       = 32;

  localparam int AxisW     = $clog2(GridSize);
  localparam int CellCount = GridSize * GridSize * GridSize;
  localparam int AddrW     = $clog2(CellCount);
  localparam int WtW       = WeightBits + 1;
  localparam int NShift    = 2 * FracBits - WeightBits + 1;
  localparam int ProdW     = WtW + ValW;
  localparam int AddW      = ProdW - WeightBits;

  localparam logic [ValW-1:0] DepositWeightReset = ValW'(65536);

  localparam logic OP_DEPOSIT = 1'b0;
  localparam logic OP_READ    = 1'b1;

  typedef struct packed {
    logic [AxisW-1:0] home;
    logic [AxisW-1:0] nbr;
    logic [WtW-1:0]   w_home;
    logic [WtW-1:0]   w_nbr;
  } axis_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_READ
  } state_t;

endpackage

>>> sv/pdd_axis.sv
// Per-axis cell selection and two-point weights, registered on load.
module pdd_axis
  import pdd_pkg::*;
(
  input  logic            clk,
  input  logic            load,
  input  logic [PosW-1:0] pos,
  output axis_t           ax
);

  localparam logic [FracBits-1:0]   Half   = FracBits'(1) << (FracBits - 1);
  localparam logic [2*FracBits:0]   NRound = (2 * FracBits + 1)'(1) << (2 * FracBits - WeightBits);
  localparam logic [WtW-1:0]        One    = WtW'(1) << WeightBits;
  localparam logic [AxisW-1:0]      LastCell = AxisW'(GridSize - 1);

  logic [FracBits-1:0]      frac;
  logic [FracBits-1:0]      dnear;
  logic [FracBits-1:0]      ecc;
  logic [PosW-FracBits-1:0] ipart;
  logic [AxisW-1:0]         home;
  logic [AxisW-1:0]         nbr;
  logic [2*FracBits:0]      esq;
  logic [WtW-1:0]           nw;
  logic                     above;

  always_comb begin
    frac  = pos[FracBits-1:0];
    ipart = pos[PosW-1:FracBits];
    above = frac > Half;
    dnear = above ? (~frac + FracBits'(1)) : frac;
    ecc   = Half - dnear;
    esq   = (2 * FracBits + 1)'(ecc) * (2 * FracBits + 1)'(ecc);
    nw    = WtW'((esq + NRound) >> NShift);
    home  = AxisW'(ipart % GridSize);
    if (above) begin
      nbr = (home == LastCell) ? '0 : home + AxisW'(1);
    end else begin
      nbr = (home == '0) ? LastCell : home - AxisW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ax.home   <= home;
      ax.nbr    <= nbr;
      ax.w_nbr  <= nw;
      ax.w_home <= One - nw;
    end
  end

endmodule

>>> sv/particle_density_deposit_unit.sv
// Top level of the particle density deposit unit with the grid memory and its update pipeline.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  input   | in_valid, in_stall, opcode, pos_x/y/z, cell_index | in, in_stall out
//  output  | out_valid, out_stall, cell_value, overflow_seen   | out, out_stall in
//  config  | cfg_valid, cfg_ready, deposit_weight              | in, cfg_ready out
//
// A deposit keeps in_stall high after its transfer while eight cell updates are issued one
// per cycle through the single read port and the single write port of the grid memory, while
// the last updates drain, and while the unit returns to idle. The next transfer can come after that.
// A read keeps in_stall high until the output register is free to take the result.
// After reset a clearing pass writes zero to every one of the GridSize**3 (262144) cells,
// while in_stall stays high; configuration transfers are taken throughout.
module particle_density_deposit_unit
  import pdd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            opcode,
  input  logic [PosW-1:0] pos_x,
  input  logic [PosW-1:0] pos_y,
  input  logic [PosW-1:0] pos_z,
  input  logic [IdxW-1:0] cell_index,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [ValW-1:0] cell_value,
  output logic            overflow_seen,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [ValW-1:0] deposit_weight
);

  localparam logic [2*WtW-1:0] RoundW = (2 * WtW)'(1) << (WeightBits - 1);
  localparam logic [ProdW-1:0] RoundP = ProdW'(1) << (WeightBits - 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(CellCount - 1);

  state_t state, state_next;

  logic [ValW-1:0]  dep_weight;
  logic [2:0]       cnt;
  logic [AddrW-1:0] clr_addr;
  logic [IdxW-1:0]  idx_q;
  logic             sticky;
  logic             in_accept;
  logic             load_axes;
  logic             out_free;
  logic             load_out;
  logic             in_range;

  axis_t ax_x, ax_y, ax_z;

  logic [AxisW-1:0] cx, cy, cz;
  logic [WtW-1:0]   wx, wy, wz;
  logic [AddrW-1:0] cell_addr;
  logic [2*WtW-1:0] pxy_full;
  logic [2*WtW-1:0] w_full;
  logic [ProdW-1:0] add_full;

  logic             s1_valid, s2_valid, s3_valid;
  logic [AddrW-1:0] s1_addr, s2_addr, s3_addr;
  logic [WtW-1:0]   s1_pxy, s1_wz, s2_w;
  logic [AddW-1:0]  s3_addend;

  logic [ValW-1:0]  grid [CellCount];
  logic [ValW-1:0]  rdata;
  logic [AddrW-1:0] raddr;
  logic [AddrW-1:0] waddr;
  logic [ValW-1:0]  wdata;
  logic             we;
  logic [AddW:0]    sum;
  logic             sat;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign load_axes = in_accept && (opcode == OP_DEPOSIT);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign load_out  = (state == ST_READ) && out_free;
  assign in_range  = {1'b0, idx_q} < (IdxW + 1)'(CellCount);

  pdd_axis u_axis_x (.clk(clk), .load(load_axes), .pos(pos_x), .ax(ax_x));
  pdd_axis u_axis_y (.clk(clk), .load(load_axes), .pos(pos_y), .ax(ax_y));
  pdd_axis u_axis_z (.clk(clk), .load(load_axes), .pos(pos_z), .ax(ax_z));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LastAddr) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) state_next = (opcode == OP_READ) ? ST_READ : ST_RUN;
      end
      ST_RUN: begin
        if (cnt == 3'd7) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!s1_valid && !s2_valid && !s3_valid) state_next = ST_IDLE;
      end
      ST_READ: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dep_weight <= DepositWeightReset;
      clr_addr   <= '0;
      cnt        <= '0;
      sticky     <= 1'b0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) dep_weight <= deposit_weight;
      if (state == ST_CLEAR) clr_addr <= clr_addr + AddrW'(1);
      if (in_accept) begin
        cnt <= '0;
      end else if (state == ST_RUN) begin
        cnt <= cnt + 3'd1;
      end
      if (s3_valid && sat) sticky <= 1'b1;
      s1_valid <= (state == ST_RUN);
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cx        = cnt[2] ? ax_x.nbr : ax_x.home;
    cy        = cnt[1] ? ax_y.nbr : ax_y.home;
    cz        = cnt[0] ? ax_z.nbr : ax_z.home;
    wx        = cnt[2] ? ax_x.w_nbr : ax_x.w_home;
    wy        = cnt[1] ? ax_y.w_nbr : ax_y.w_home;
    wz        = cnt[0] ? ax_z.w_nbr : ax_z.w_home;
    cell_addr = AddrW'(cz) + AddrW'(GridSize) * (AddrW'(cy) + AddrW'(GridSize) * AddrW'(cx));
    pxy_full  = (2 * WtW)'(wx) * (2 * WtW)'(wy);
    w_full    = (2 * WtW)'(s1_pxy) * (2 * WtW)'(s1_wz);
    add_full  = ProdW'(s2_w) * ProdW'(dep_weight);
    sum       = (AddW + 1)'(rdata) + (AddW + 1)'(s3_addend);
    sat       = sum > (AddW + 1)'({ValW{1'b1}});
  end

  always_ff @(posedge clk) begin
    s1_addr   <= cell_addr;
    s1_pxy    <= WtW'((pxy_full + RoundW) >> WeightBits);
    s1_wz     <= wz;
    s2_addr   <= s1_addr;
    s2_w      <= WtW'((w_full + RoundW) >> WeightBits);
    s3_addr   <= s2_addr;
    s3_addend <= AddW'((add_full + RoundP) >> WeightBits);
    if (in_accept) idx_q <= cell_index;
    if (load_out) begin
      cell_value    <= in_range ? rdata : '0;
      overflow_seen <= sticky;
    end
  end

  always_comb begin
    case (state)
      ST_IDLE: raddr = AddrW'(cell_index);
      ST_READ: raddr = AddrW'(idx_q);
      default: raddr = s2_addr;
    endcase
    we    = (state == ST_CLEAR) || s3_valid;
    waddr = (state == ST_CLEAR) ? clr_addr : s3_addr;
    if (state == ST_CLEAR) begin
      wdata = '0;
    end else begin
      wdata = sat ? {ValW{1'b1}} : sum[ValW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) grid[waddr] <= wdata;
    rdata <= grid[raddr];
  end

endmodule

>>> sv/pdd_checker.sv
// Port-level checker for the particle density deposit unit and its bind.
module pdd_checker
  import pdd_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic            opcode,
  input logic            out_valid,
  input logic            out_stall,
  input logic [ValW-1:0] cell_value,
  input logic            overflow_seen
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cell_value))
    else $error("stalled result changed");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input taken during clearing pass");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow_seen |=> !out_valid || overflow_seen)
    else $error("overflow flag dropped");

  a_deposit_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (opcode == OP_DEPOSIT) |=> in_stall && !$rose(out_valid))
    else $error("deposit transfer not followed by busy or produced a result");

endmodule

bind particle_density_deposit_unit pdd_checker u_pdd_checker (.*);

>>> dv/particle_density_deposit_unit_test.sv
// Self-checking testbench for the particle density deposit unit with its own grid model.
`timescale 1ns / 1ps

module particle_density_deposit_unit_test;
  import pdd_pkg::*;

  localparam int WatchdogLimit = 1000000;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic            opcode = OP_DEPOSIT;
  logic [PosW-1:0] pos_x = '0;
  logic [PosW-1:0] pos_y = '0;
  logic [PosW-1:0] pos_z = '0;
  logic [IdxW-1:0] cell_index = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [ValW-1:0] cell_value;
  logic            overflow_seen;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [ValW-1:0] deposit_weight = DepositWeightReset;

  particle_density_deposit_unit dut (.*);

  always #6 clk = ~clk;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            flag;
  } cell_read_t;

  cell_read_t      pending_reads[$];
  logic [ValW-1:0] density_model[int];
  logic            overflow_model = 1'b0;
  logic [ValW-1:0] mass_per_particle = DepositWeightReset;
  int              errors = 0;
  int              idle_pct = 0;
  int              stall_pct = 0;
  int              hold_cycles = 0;
  int              quiet_cycles = 0;

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cell_read_t exp_read;
    if (out_valid && !out_stall) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected cell read result %h", $time, cell_value);
        errors++;
      end else begin
        exp_read = pending_reads.pop_front();
        if (cell_value !== exp_read.value) begin
          $display("%0t: cell_value expected %h actual %h", $time, exp_read.value, cell_value);
          errors++;
        end
        if (overflow_seen !== exp_read.flag) begin
          $display("%0t: overflow_seen expected %b actual %b", $time, exp_read.flag,
                   overflow_seen);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("particle_density_deposit_unit_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic longint unsigned round_q16(longint unsigned p);
    return (p + 64'd32768) >> WeightBits;
  endfunction

  function automatic void split_axis(input logic [PosW-1:0] p, output int home, output int nbr,
                                     output longint unsigned w_home,
                                     output longint unsigned w_nbr);
    longint unsigned f, d, e;
    f = p[FracBits-1:0];
    home = p[PosW-1:FracBits] % GridSize;
    if (f > 32768) begin
      d = 65536 - f;
      nbr = (home + 1) % GridSize;
    end else begin
      d = f;
      nbr = (home + GridSize - 1) % GridSize;
    end
    e = 32768 - d;
    w_nbr = (e * e + 64'd65536) >> NShift;
    w_home = 65536 - w_nbr;
  endfunction

  function automatic void accumulate_cell(int cx, int cy, int cz, longint unsigned wx,
                                          longint unsigned wy, longint unsigned wz);
    longint unsigned w, addend, sum;
    int addr;
    w = round_q16(round_q16(wx * wy) * wz);
    addend = round_q16(w * mass_per_particle);
    addr = cz + GridSize * (cy + GridSize * cx);
    sum = (density_model.exists(addr) ? density_model[addr] : 0) + addend;
    if (sum > 64'hFFFF_FFFF) begin
      sum = 64'hFFFF_FFFF;
      overflow_model = 1'b1;
    end
    density_model[addr] = sum[ValW-1:0];
  endfunction

  function automatic void predict_item(logic op, logic [PosW-1:0] px, logic [PosW-1:0] py,
                                       logic [PosW-1:0] pz, logic [IdxW-1:0] idx);
    int hx, nx, hy, ny, hz, nz;
    longint unsigned ahx, anx, ahy, any, ahz, anz;
    cell_read_t r;
    if (op == OP_DEPOSIT) begin
      split_axis(px, hx, nx, ahx, anx);
      split_axis(py, hy, ny, ahy, any);
      split_axis(pz, hz, nz, ahz, anz);
      accumulate_cell(hx, hy, hz, ahx, ahy, ahz);
      accumulate_cell(hx, hy, nz, ahx, ahy, anz);
      accumulate_cell(hx, ny, hz, ahx, any, ahz);
      accumulate_cell(hx, ny, nz, ahx, any, anz);
      accumulate_cell(nx, hy, hz, anx, ahy, ahz);
      accumulate_cell(nx, hy, nz, anx, ahy, anz);
      accumulate_cell(nx, ny, hz, anx, any, ahz);
      accumulate_cell(nx, ny, nz, anx, any, anz);
    end else begin
      r.value = (idx < CellCount && density_model.exists(int'(idx))) ? density_model[idx] : '0;
      r.flag = overflow_model;
      pending_reads.push_back(r);
    end
  endfunction

  task automatic send_item(logic op, logic [PosW-1:0] px, logic [PosW-1:0] py,
                           logic [PosW-1:0] pz, logic [IdxW-1:0] idx);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    opcode <= op;
    pos_x <= px;
    pos_y <= py;
    pos_z <= pz;
    cell_index <= idx;
    do @(posedge clk); while (in_stall);
    predict_item(op, px, py, pz, idx);
  endtask

  task automatic settle;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_weight(logic [ValW-1:0] w);
    settle();
    cfg_valid <= 1'b1;
    deposit_weight <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mass_per_particle = w;
  endtask

  function automatic logic [PosW-1:0] pick_pos();
    logic [5:0]  ip;
    logic [15:0] fr;
    case ($urandom_range(9))
      0: ip = 6'($urandom_range(63));
      1: ip = 6'd63;
      default: ip = 6'($urandom_range(3));
    endcase
    case ($urandom_range(9))
      0: fr = 16'h8000;
      1: fr = 16'h0000;
      2: fr = 16'hFFFF;
      default: fr = 16'($urandom_range(16'hFFFF));
    endcase
    return {ip, fr};
  endfunction

  function automatic logic [IdxW-1:0] pick_cell();
    int c[3];
    if ($urandom_range(9) == 0) return IdxW'($urandom_range(CellCount - 1));
    foreach (c[i]) c[i] = ($urandom_range(5) == 0) ? 63 : $urandom_range(4);
    return IdxW'(c[2] + GridSize * (c[1] + GridSize * c[0]));
  endfunction

  task automatic random_items(int count);
    repeat (count) begin
      if ($urandom_range(99) < 55) send_item(OP_DEPOSIT, pick_pos(), pick_pos(), pick_pos(),
                                             IdxW'($urandom));
      else send_item(OP_READ, PosW'($urandom), PosW'($urandom), PosW'($urandom), pick_cell());
    end
  endtask

  task automatic test_directed;
    send_item(OP_READ, '0, '0, '0, '0);
    send_item(OP_DEPOSIT, '0, '0, '0, '0);
    send_item(OP_DEPOSIT, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, '1);
    send_item(OP_DEPOSIT, 22'h018000, 22'h018000, 22'h018000, '0);
    send_item(OP_DEPOSIT, 22'h018001, 22'h017FFF, 22'h028001, '0);
    send_item(OP_DEPOSIT, 22'h3F8001, 22'h3F0000, 22'h3FC000, '0);
    send_item(OP_READ, '0, '0, '0, '0);
    send_item(OP_READ, '0, '0, '0, 18'h3FFFF);
    send_item(OP_READ, '0, '0, '0, 18'd63);
    send_item(OP_READ, '0, '0, '0, 18'd4095);
    send_item(OP_READ, '0, '0, '0, 18'h3F000);
    send_item(OP_READ, '0, '0, '0, IdxW'(1 + 64 * (1 + 64)));
    send_item(OP_READ, '0, '0, '0, IdxW'(2 + 64 * (1 + 64)));
    send_item(OP_READ, '0, '0, '0, IdxW'(0 + 64 * (1 + 64)));
    send_item(OP_READ, '0, '0, '0, IdxW'(2 + 64 * (2 + 64 * 2)));
    send_item(OP_READ, '0, '0, '0, IdxW'(0 + 64 * (63 + 64 * 63)));
    send_item(OP_READ, '1, '1, '1, IdxW'(63 + 64 * (63 + 64 * 62)));
  endtask

  task automatic test_weight_settings;
    write_weight('0);
    random_items(100);
    write_weight(32'd1);
    random_items(100);
    write_weight($urandom);
    random_items(100);
    write_weight(32'h0010_0000);
    random_items(100);
    write_weight(DepositWeightReset);
  endtask

  task automatic test_random_idling;
    idle_pct = 8;
    stall_pct = 78;
    random_items(400);
    idle_pct = 78;
    stall_pct = 8;
    random_items(400);
    idle_pct = 0;
    stall_pct = 0;
    random_items(400);
  endtask

  task automatic test_backpressure;
    @(posedge clk);
    hold_cycles = 300;
    repeat (40) send_item(OP_READ, '0, '0, '0, pick_cell());
  endtask

  task automatic test_saturation;
    write_weight(32'hFFFF_FFFF);
    repeat (6) send_item(OP_DEPOSIT, 22'h010000, 22'h010000, 22'h010000, '0);
    send_item(OP_READ, '0, '0, '0, IdxW'(1 + 64 * (1 + 64)));
    random_items(30);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_weight_settings();
    test_random_idling();
    test_backpressure();
    test_saturation();
    settle();
    if (errors == 0) begin
      $display("particle_density_deposit_unit_test: done, clean");
    end else begin
      $display("particle_density_deposit_unit_test: done, errors");
    end
    $finish;
  end

endmodule
